FILE: sv/byte_rle_codec_assert.svh
// assertion macros shared by the byte run-length codec modules
`ifndef BYTE_RLE_CODEC_ASSERT_SVH
`define BYTE_RLE_CODEC_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/brc_pkg.sv
// types and constants of the byte run-length codec
`timescale 1ns / 1ps

package brc_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  localparam logic [7:0] RunMax = 8'd255;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_res;
    logic       last_of_item;
  } out_res_t;

  // results caused by one input request; only the first can repeat
  typedef struct packed {
    res_cnt_t   num;
    logic [7:0] byte0;
    logic [7:0] rep0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } cmd_t;

endpackage

FILE: sv/brc_front.sv
// front end: mode register, stream state and classification of each request
`timescale 1ns / 1ps
`include "byte_rle_codec_assert.svh"

module brc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_mode_i,
  input  logic             in_valid_i,
  input  brc_pkg::in_req_t in_req_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output brc_pkg::cmd_t    cmd_o
);

  brc_pkg::mode_e mode_q;
  logic [7:0]     prev_q, prev_d;
  logic           pv_q, pv_d;
  logic           run_q, run_d;
  logic [7:0]     cnt_q, cnt_d;
  logic [7:0]     b;
  logic           same;
  logic           accept;

  assign b          = in_req_i.data_byte;
  assign same       = pv_q && (b == prev_q);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (cmd_o.num != 2'd0);

  always_comb begin
    prev_d      = prev_q;
    pv_d        = pv_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    cmd_o.num   = 2'd0;
    cmd_o.byte0 = '0;
    cmd_o.rep0  = 8'd1;
    cmd_o.byte1 = '0;
    cmd_o.byte2 = '0;
    unique case (mode_q)
      brc_pkg::MODE_ENCODE: begin
        if (run_q) begin
          if ((b == prev_q) && (cnt_q != brc_pkg::RunMax)) begin
            cnt_d = cnt_q + 8'd1;
            if (in_req_i.stream_end) begin
              cmd_o.num   = 2'd2;
              cmd_o.byte0 = prev_q;
              cmd_o.byte1 = cnt_d;
            end
          end else begin
            // run closed: byte, count, then the new literal
            cmd_o.num   = 2'd3;
            cmd_o.byte0 = prev_q;
            cmd_o.byte1 = cnt_q;
            cmd_o.byte2 = b;
            run_d       = 1'b0;
            cnt_d       = '0;
            prev_d      = b;
            pv_d        = 1'b1;
          end
        end else if (same) begin
          run_d = 1'b1;
          cnt_d = '0;
          if (in_req_i.stream_end) begin
            cmd_o.num   = 2'd2;
            cmd_o.byte0 = prev_q;
            cmd_o.byte1 = '0;
          end
        end else begin
          cmd_o.num   = 2'd1;
          cmd_o.byte0 = b;
          prev_d      = b;
          pv_d        = 1'b1;
        end
      end
      brc_pkg::MODE_DECODE: begin
        if (run_q) begin
          // count byte; zero count gives nothing
          if (b != 8'd0) begin
            cmd_o.num   = 2'd1;
            cmd_o.byte0 = prev_q;
            cmd_o.rep0  = b;
          end
          run_d  = 1'b0;
          pv_d   = 1'b0;
          prev_d = '0;
        end else begin
          cmd_o.num   = 2'd1;
          cmd_o.byte0 = b;
          if (same) begin
            run_d = 1'b1;
          end else begin
            prev_d = b;
            pv_d   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (in_req_i.stream_end) begin
      prev_d = '0;
      pv_d   = 1'b0;
      run_d  = 1'b0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= brc_pkg::MODE_ENCODE;
      prev_q <= '0;
      pv_q   <= 1'b0;
      run_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (cfg_valid_i) begin
      mode_q <= brc_pkg::mode_e'(cfg_mode_i);
      prev_q <= '0;
      pv_q   <= 1'b0;
      run_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
      pv_q   <= pv_d;
      run_q  <= run_d;
      cnt_q  <= cnt_d;
    end
  end

  `BRC_ASSERT_IMPL(a_run_has_prev, clk_i, rst_ni, run_q, pv_q, "run open without previous byte")
  `BRC_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, q_full_i, !push_o, "push into full queue")

endmodule

FILE: sv/brc_queue.sv
// short queue of classified requests between front and back end
`timescale 1ns / 1ps
`include "byte_rle_codec_assert.svh"

module brc_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  brc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output brc_pkg::cmd_t cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  brc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `BRC_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FullCnt, "queue count overflow")

endmodule

FILE: sv/brc_back.sv
// back end: walks the results of the head entry, one per cycle while out_ready_i is high
`timescale 1ns / 1ps
`include "byte_rle_codec_assert.svh"

module brc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  brc_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output brc_pkg::out_res_t  out_res_o
);

  brc_pkg::res_cnt_t idx_q;
  logic              last;
  logic              take;

  assign out_valid_o = q_valid_i;
  assign last        = (idx_q == (cmd_i.num - 2'd1));
  assign take        = out_valid_o && out_ready_i;
  assign pop_o       = take && last;

  always_comb begin
    case (idx_q)
      2'd0:    out_res_o.out_byte = cmd_i.byte0;
      2'd1:    out_res_o.out_byte = cmd_i.byte1;
      default: out_res_o.out_byte = cmd_i.byte2;
    endcase
    out_res_o.repeat_res   = (idx_q == 2'd0) ? cmd_i.rep0 : 8'd1;
    out_res_o.last_of_item = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  `BRC_ASSERT_IMPL(a_idx_in_entry, clk_i, rst_ni, q_valid_i,
                   (cmd_i.num != 2'd0) && (idx_q < cmd_i.num), "result index past entry")

endmodule

FILE: sv/byte_rle_codec.sv
// Byte run-length codec, double-byte escape, encode or decode by mode.
// Channels: in (in_valid_i/in_ready_o, in_req_i) takes one byte per request
// with a stream end flag; out (out_valid_o/out_ready_i, out_res_o) gives zero
// to three results per request: a byte, its repeat number and a last-of-item flag.
// cfg (cfg_valid_i/cfg_ready_o, cfg_mode_i) writes the mode, 0 encode and
// 1 decode; it is always ready, and every write clears the stream state.
// A request is classified in the cycle it is taken and its results, if any,
// go into one entry of a QDepth-entry queue; the first result is offered
// once the entries ahead are sent. The back end sends one result per cycle
// while out_ready_i is high, so the rate is one request per cycle if each has
// at most one result; a request with three results holds the output until all are sent.
// The input is taken whenever the queue has room, so a stalled receiver
// only stops the input once QDepth requests with results are waiting.
// Reset: mode encode, no previous byte, no open run, queue empty.
`timescale 1ns / 1ps

module byte_rle_codec #(
  parameter int QDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_mode_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brc_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brc_pkg::out_res_t out_res_o
);

  logic          q_full, q_valid, push, pop;
  brc_pkg::cmd_t cmd_in, cmd_head;

  assign cfg_ready_o = 1'b1;

  brc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_mode_i  (cfg_mode_i),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  brc_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_head)
  );

  brc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule
